// File: hw/rtl/scatr_pkg.sv
// ----------------------------------------------------------------------------
// ATR parser package
// Types and fixed codes shared by the answer-to-reset parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package scatr_pkg;

  // Parser phase codes.
  localparam logic [2:0] PH_TS    = 3'd0;
  localparam logic [2:0] PH_T0    = 3'd1;
  localparam logic [2:0] PH_IFACE = 3'd2;
  localparam logic [2:0] PH_HIST  = 3'd3;
  localparam logic [2:0] PH_CAND  = 3'd4;
  localparam logic [2:0] PH_TRAIL = 3'd5;

  // Byte class codes.
  localparam logic [3:0] CLS_TS      = 4'd0;
  localparam logic [3:0] CLS_T0      = 4'd1;
  localparam logic [3:0] CLS_TA      = 4'd2;
  localparam logic [3:0] CLS_TB      = 4'd3;
  localparam logic [3:0] CLS_TC      = 4'd4;
  localparam logic [3:0] CLS_TD      = 4'd5;
  localparam logic [3:0] CLS_HIST    = 4'd6;
  localparam logic [3:0] CLS_CHECK   = 4'd7;
  localparam logic [3:0] CLS_TRAIL   = 4'd8;
  localparam logic [3:0] CLS_IGNORED = 4'd9;

  // Status and error codes.
  localparam logic [3:0] ST_RUNNING   = 4'd0;
  localparam logic [3:0] ST_OK_NO_TCK = 4'd1;
  localparam logic [3:0] ST_TCK_MATCH = 4'd2;
  localparam logic [3:0] ST_TCK_BAD   = 4'd3;
  localparam logic [3:0] ST_TRAILING  = 4'd4;
  localparam logic [3:0] ST_BAD_TS    = 4'd5;
  localparam logic [3:0] ST_SHORT     = 4'd6;
  localparam logic [3:0] ST_LONG      = 4'd7;
  localparam logic [3:0] ST_SECTIONS  = 4'd8;

  // Initial character conventions.
  localparam logic [7:0] TS_DIRECT  = 8'h3B;
  localparam logic [7:0] TS_INVERSE = 8'h3F;

  // Byte counter saturates at its full range.
  localparam int unsigned CountWidth = 6;
  localparam logic [CountWidth-1:0] COUNT_SAT = '1;
  localparam logic [CountWidth-1:0] MIN_ATR_BYTES = CountWidth'(2);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0] byte_class;
    logic [2:0] section_number;
    logic [3:0] historical_index;
    logic [3:0] status;
    logic       done_res;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/scatr_in_if.sv
// ----------------------------------------------------------------------------
// ATR byte channel
// Valid/ready channel that carries one raw ATR byte and its last-byte flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface scatr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/scatr_out_if.sv
// ----------------------------------------------------------------------------
// ATR result channel
// Valid/ready channel that carries the classification of one ATR byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface scatr_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] byte_class;
  logic [2:0] section_number;
  logic [3:0] historical_index;
  logic [3:0] status;
  logic       done_res;

  modport source (output valid, output byte_class, output section_number,
                  output historical_index, output status, output done_res,
                  input ready);
  modport sink   (input valid, input byte_class, input section_number,
                  input historical_index, input status, input done_res,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/scatr_in_stage.sv
// ----------------------------------------------------------------------------
// ATR parser input register
// Holds one accepted byte until the parse stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module scatr_in_stage
  import scatr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  scatr_in_if.sink       in_chan,
  input  wire logic      take,
  output logic           item_valid,
  output in_item_t       item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;
  logic     accept;

  // A new request is taken when the register is empty or drains this cycle.
  assign in_chan.ready = !valid_r || take;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.data_byte <= in_chan.data_byte;
      item_r.last_byte <= in_chan.last_byte;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// File: hw/rtl/scatr_step.sv
// ----------------------------------------------------------------------------
// ATR parser state update
// Classifies one byte against the parser state and computes the new state.
// ----------------------------------------------------------------------------
`default_nettype none

module scatr_step
  import scatr_pkg::*;
#(
  parameter int unsigned MAX_ATR_BYTES = 33,
  parameter int unsigned MAX_SECTIONS  = 7
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      fire,
  input  wire in_item_t  item,
  output res_t           res
);

  localparam logic [CountWidth-1:0] MaxBytes = CountWidth'(MAX_ATR_BYTES);
  localparam logic [2:0]            MaxSect  = 3'(MAX_SECTIONS);

  logic [2:0]            phase_r, phase_nxt;
  logic [3:0]            pend_r, pend_nxt;
  logic [2:0]            sect_r, sect_nxt;
  logic [3:0]            hist_total_r, hist_total_nxt;
  logic [3:0]            hist_seen_r, hist_seen_nxt;
  logic [CountWidth-1:0] count_r, count_nxt;
  logic [7:0]            xor_r, xor_nxt;
  logic [3:0]            err_r, err_nxt;

  logic [7:0] b;
  logic [3:0] cls;
  logic [2:0] sec;
  logic [3:0] hidx;
  logic [3:0] status;

  assign b = item.data_byte;

  // Byte classification and next state.
  always_comb begin
    phase_nxt      = phase_r;
    pend_nxt       = pend_r;
    sect_nxt       = sect_r;
    hist_total_nxt = hist_total_r;
    hist_seen_nxt  = hist_seen_r;
    xor_nxt        = xor_r;
    err_nxt        = err_r;
    cls            = CLS_IGNORED;
    sec            = 3'd0;
    hidx           = 4'd0;

    if (count_r >= MaxBytes) begin
      err_nxt = ST_LONG;
    end else if (err_r == ST_RUNNING) begin
      case (phase_r)
        PH_TS: begin
          cls = CLS_TS;
          if (b != TS_DIRECT && b != TS_INVERSE) begin
            err_nxt = ST_BAD_TS;
          end
          phase_nxt = PH_T0;
        end
        PH_T0: begin
          cls            = CLS_T0;
          xor_nxt        = xor_r ^ b;
          hist_total_nxt = b[3:0];
          pend_nxt       = b[7:4];
          sect_nxt       = 3'd1;
          if (b[7:4] == 4'd0) begin
            phase_nxt = (b[3:0] != 4'd0) ? PH_HIST : PH_CAND;
          end else begin
            phase_nxt = PH_IFACE;
          end
        end
        PH_IFACE: begin
          xor_nxt = xor_r ^ b;
          sec     = sect_r;
          if (pend_r[0]) begin
            cls      = CLS_TA;
            pend_nxt = pend_r & 4'hE;
          end else if (pend_r[1]) begin
            cls      = CLS_TB;
            pend_nxt = pend_r & 4'hC;
          end else if (pend_r[2]) begin
            cls      = CLS_TC;
            pend_nxt = pend_r & 4'h8;
          end else begin
            cls = CLS_TD;
            if (sect_r >= MaxSect) begin
              err_nxt  = ST_SECTIONS;
              pend_nxt = 4'd0;
            end else begin
              sect_nxt = sect_r + 3'd1;
              pend_nxt = b[7:4];
            end
          end
          // Interface bytes exhausted: move on to the historical bytes, or to the check byte when there are none.
          if (err_nxt == ST_RUNNING && pend_nxt == 4'd0) begin
            phase_nxt = (hist_total_r != 4'd0) ? PH_HIST : PH_CAND;
          end
        end
        PH_HIST: begin
          cls           = CLS_HIST;
          hidx          = hist_seen_r;
          xor_nxt       = xor_r ^ b;
          hist_seen_nxt = hist_seen_r + 4'd1;
          if (hist_seen_nxt >= hist_total_r) begin
            phase_nxt = PH_CAND;
          end
        end
        PH_CAND: begin
          cls       = CLS_CHECK;
          xor_nxt   = xor_r ^ b;
          phase_nxt = PH_TRAIL;
        end
        default: begin
          cls       = CLS_TRAIL;
          phase_nxt = PH_TRAIL;
        end
      endcase
    end

    count_nxt = (count_r != COUNT_SAT) ? count_r + CountWidth'(1) : count_r;
  end

  // Status reported with this byte.
  always_comb begin
    if (!item.last_byte) begin
      status = err_nxt;
    end else if (err_nxt == ST_LONG) begin
      status = ST_LONG;
    end else if (count_nxt < MIN_ATR_BYTES) begin
      status = ST_SHORT;
    end else if (err_nxt != ST_RUNNING) begin
      status = err_nxt;
    end else if (phase_nxt == PH_CAND) begin
      status = ST_OK_NO_TCK;
    end else if (phase_nxt == PH_TRAIL) begin
      if (cls == CLS_CHECK) begin
        status = (xor_nxt == 8'd0) ? ST_TCK_MATCH : ST_TCK_BAD;
      end else begin
        status = ST_TRAILING;
      end
    end else begin
      status = ST_SHORT;
    end
  end

  assign res.byte_class       = cls;
  assign res.section_number   = sec;
  assign res.historical_index = hidx;
  assign res.status           = status;
  assign res.done_res         = item.last_byte;

  // State registers; the final byte of an ATR returns everything to reset.
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && item.last_byte)) begin
      phase_r      <= PH_TS;
      pend_r       <= 4'd0;
      sect_r       <= 3'd1;
      hist_total_r <= 4'd0;
      hist_seen_r  <= 4'd0;
      count_r      <= '0;
      xor_r        <= 8'd0;
      err_r        <= ST_RUNNING;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      pend_r       <= pend_nxt;
      sect_r       <= sect_nxt;
      hist_total_r <= hist_total_nxt;
      hist_seen_r  <= hist_seen_nxt;
      count_r      <= count_nxt;
      xor_r        <= xor_nxt;
      err_r        <= err_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/scatr_out_stage.sv
// ----------------------------------------------------------------------------
// ATR parser result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module scatr_out_stage
  import scatr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      res_valid,
  input  wire res_t      res,
  output logic           take,
  scatr_out_if.source    out_chan
);

  logic valid_r, valid_nxt;
  res_t res_r;
  logic load;

  // The register can load when empty or when its content leaves this cycle.
  assign take = !valid_r || out_chan.ready;
  assign load = res_valid && take;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_chan.valid            = valid_r;
  assign out_chan.byte_class       = res_r.byte_class;
  assign out_chan.section_number   = res_r.section_number;
  assign out_chan.historical_index = res_r.historical_index;
  assign out_chan.status           = res_r.status;
  assign out_chan.done_res         = res_r.done_res;

endmodule

`default_nettype wire

// File: hw/rtl/smart_card_atr_parser.sv
// ----------------------------------------------------------------------------
// Smart-card ATR parser
// Classifies answer-to-reset bytes and reports a running and final status.
// ----------------------------------------------------------------------------
// The parser takes one ATR byte per clock and returns one result per byte;
// each byte passes through the input register and then the result register.
// Throughput is one byte per cycle, set by the parser state update, and
// holds while the result side takes every cycle; while a result waits, the
// input register takes one more byte and the input then stalls until the
// result leaves. The status is final on the result flagged done_res, after
// which the parser starts a new ATR on the next byte.
`default_nettype none

module smart_card_atr_parser
  import scatr_pkg::*;
#(
  parameter int unsigned MAX_ATR_BYTES = 33,
  parameter int unsigned MAX_SECTIONS  = 7
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  scatr_in_if.sink       in_chan,
  scatr_out_if.source    out_chan
);

  logic     item_valid;
  in_item_t item;
  logic     take;
  res_t     res;
  logic     fire;

  // A byte moves through the parse logic when the result register is empty or its content leaves this cycle.
  assign fire = item_valid && take;

  scatr_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  scatr_step #(
    .MAX_ATR_BYTES (MAX_ATR_BYTES),
    .MAX_SECTIONS  (MAX_SECTIONS)
  ) u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .res   (res)
  );

  scatr_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (item_valid),
    .res       (res),
    .take      (take),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

// File: hw/rtl/scatr_checker.sv
// ----------------------------------------------------------------------------
// ATR parser port checker
// Concurrent checks on the result channel of the ATR parser.
// ----------------------------------------------------------------------------
`default_nettype none

module scatr_checker
  import scatr_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] out_byte_class,
  input wire logic [3:0] out_status,
  input wire logic       out_done_res
);

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its status.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status))
    else $error("result status changed while stalled");

  // The final status of an ATR is never the running code.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_status != ST_RUNNING)
    else $error("final status reports running");

  // Completion codes appear only on the last byte of an ATR.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK_NO_TCK || out_status == ST_TCK_MATCH ||
                  out_status == ST_TCK_BAD || out_status == ST_TRAILING)
    |-> out_done_res)
    else $error("completion status before the last byte");

  // While running without error, no byte is ignored.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_RUNNING |-> out_byte_class != CLS_IGNORED)
    else $error("byte ignored without an error");

endmodule

bind smart_card_atr_parser scatr_checker u_scatr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_byte_class (out_chan.byte_class),
  .out_status     (out_chan.status),
  .out_done_res   (out_chan.done_res)
);

`default_nettype wire

// File: bench/smart_card_atr_parser_test.sv
// ----------------------------------------------------------------------------
// Smart-card ATR parser testbench
// Feeds answer-to-reset byte streams through the parser under random flow
// control and checks every per-byte classification and status against a
// cycle-free model of the ATR structure rules held in a scoreboard.
// ----------------------------------------------------------------------------

module smart_card_atr_parser_test;
  import scatr_pkg::*;

  localparam int unsigned ATR_LEN_LIMIT = 33;
  localparam int unsigned SECTION_LIMIT = 7;
  localparam int unsigned BYTE_TARGET   = 1250;
  localparam int unsigned HOLD_CYCLES   = 250;
  localparam int unsigned HOLD_AFTER    = 300;

  logic clk;
  logic rst_n;

  scatr_in_if  byte_bus ();
  scatr_out_if result_bus ();

  smart_card_atr_parser #(
    .MAX_ATR_BYTES (ATR_LEN_LIMIT),
    .MAX_SECTIONS  (SECTION_LIMIT)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (byte_bus),
    .out_chan (result_bus)
  );

  // Scoreboard: tracks the ATR structure and queues the classification that
  // each accepted byte request should produce.
  class atr_checker;
    logic [2:0] phase;
    logic [3:0] ind;
    logic [2:0] sec_ctr;
    logic [3:0] hist_total;
    logic [3:0] hist_seen;
    logic [5:0] nbytes;
    logic [7:0] xsum;
    logic [3:0] err;

    res_t        awaited[$];
    int unsigned errors;
    int unsigned parsed;
    int unsigned ignored;
    int unsigned checked;
    logic [15:0] final_seen;
    logic [15:0] class_seen;

    function new();
      restart();
      errors     = 0;
      parsed     = 0;
      ignored    = 0;
      checked    = 0;
      final_seen = '0;
      class_seen = '0;
    endfunction

    // Every ATR starts from the same parser state.
    function void restart();
      phase      = PH_TS;
      ind        = 4'd0;
      sec_ctr    = 3'd1;
      hist_total = 4'd0;
      hist_seen  = 4'd0;
      nbytes     = 6'd0;
      xsum       = 8'd0;
      err        = ST_RUNNING;
    endfunction

    function res_t predict_byte(logic [7:0] b, logic is_last);
      res_t       r;
      logic [3:0] cls;
      logic [3:0] st;
      logic [2:0] sec;
      logic [3:0] hidx;
      cls  = CLS_IGNORED;
      sec  = 3'd0;
      hidx = 4'd0;

      // A byte beyond the length limit overrides any earlier error.
      if (nbytes >= ATR_LEN_LIMIT) begin
        err = ST_LONG;
      end else if (err == ST_RUNNING) begin
        case (phase)
          PH_TS: begin
            cls = CLS_TS;
            if (b != TS_DIRECT && b != TS_INVERSE) err = ST_BAD_TS;
            phase = PH_T0;
          end
          PH_T0: begin
            cls        = CLS_T0;
            xsum       = xsum ^ b;
            hist_total = b[3:0];
            ind        = b[7:4];
            sec_ctr    = 3'd1;
            if (ind == 4'd0) begin
              phase = (hist_total != 4'd0) ? PH_HIST : PH_CAND;
            end else begin
              phase = PH_IFACE;
            end
          end
          PH_IFACE: begin
            xsum = xsum ^ b;
            sec  = sec_ctr;
            if (ind[0]) begin
              cls    = CLS_TA;
              ind[0] = 1'b0;
            end else if (ind[1]) begin
              cls    = CLS_TB;
              ind[1] = 1'b0;
            end else if (ind[2]) begin
              cls    = CLS_TC;
              ind[2] = 1'b0;
            end else begin
              // A TD byte opens the next section unless the last one is reached.
              cls = CLS_TD;
              if (sec_ctr >= SECTION_LIMIT) begin
                err = ST_SECTIONS;
                ind = 4'd0;
              end else begin
                sec_ctr = sec_ctr + 3'd1;
                ind     = b[7:4];
              end
            end
            if (err == ST_RUNNING && ind == 4'd0) begin
              phase = (hist_total != 4'd0) ? PH_HIST : PH_CAND;
            end
          end
          PH_HIST: begin
            cls       = CLS_HIST;
            hidx      = hist_seen;
            xsum      = xsum ^ b;
            hist_seen = hist_seen + 4'd1;
            if (hist_seen >= hist_total) phase = PH_CAND;
          end
          PH_CAND: begin
            cls   = CLS_CHECK;
            xsum  = xsum ^ b;
            phase = PH_TRAIL;
          end
          default: begin
            cls   = CLS_TRAIL;
            phase = PH_TRAIL;
          end
        endcase
      end

      if (nbytes != 6'd63) nbytes = nbytes + 6'd1;

      // The status is the sticky error until the final byte resolves it.
      if (!is_last) begin
        st = err;
      end else if (err == ST_LONG) begin
        st = ST_LONG;
      end else if (nbytes < 6'd2) begin
        st = ST_SHORT;
      end else if (err != ST_RUNNING) begin
        st = err;
      end else if (phase == PH_CAND) begin
        st = ST_OK_NO_TCK;
      end else if (phase == PH_TRAIL) begin
        if (cls == CLS_CHECK) begin
          st = (xsum == 8'd0) ? ST_TCK_MATCH : ST_TCK_BAD;
        end else begin
          st = ST_TRAILING;
        end
      end else begin
        st = ST_SHORT;
      end

      r.byte_class       = cls;
      r.section_number   = sec;
      r.historical_index = hidx;
      r.status           = st;
      r.done_res         = is_last;
      if (is_last) begin
        final_seen[st] = 1'b1;
        restart();
      end
      return r;
    endfunction

    // Called for each byte request the parser accepts.
    function void note_byte(logic [7:0] b, logic is_last);
      res_t r;
      r = predict_byte(b, is_last);
      class_seen[r.byte_class] = 1'b1;
      if (r.byte_class == CLS_IGNORED) ignored++;
      else parsed++;
      awaited.push_back(r);
    endfunction

    // Called for each result the parser hands over.
    function void check_result(res_t got);
      res_t exp;
      checked++;
      if (awaited.size() == 0) begin
        $error("unexpected result: class %0d status %0d", got.byte_class, got.status);
        errors++;
        return;
      end
      exp = awaited.pop_front();
      if (got.byte_class != exp.byte_class) begin
        $error("byte_class: expected %0d, got %0d", exp.byte_class, got.byte_class);
        errors++;
      end
      if (got.section_number != exp.section_number) begin
        $error("section_number: expected %0d, got %0d",
               exp.section_number, got.section_number);
        errors++;
      end
      if (got.historical_index != exp.historical_index) begin
        $error("historical_index: expected %0d, got %0d",
               exp.historical_index, got.historical_index);
        errors++;
      end
      if (got.status != exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.done_res != exp.done_res) begin
        $error("done_res: expected %0d, got %0d", exp.done_res, got.done_res);
        errors++;
      end
    endfunction
  endclass

  atr_checker  atr_check;
  logic [7:0]  atr_bytes[$];
  int unsigned burst_left;
  int unsigned frames;

  // Clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Offer one byte request and wait for it to be taken; the sender idles
  // between bursts of random length.
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    byte_bus.valid     <= 1'b1;
    byte_bus.data_byte <= value;
    byte_bus.last_byte <= is_last;
    @(posedge clk);
    while (!byte_bus.ready) @(posedge clk);
    atr_check.note_byte(value, is_last);
    if (burst_left == 0) begin
      byte_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 10);
    end else begin
      burst_left--;
    end
  endtask

  // Send the prepared ATR, flagging its final byte.
  task automatic send_atr();
    for (int i = 0; i < atr_bytes.size(); i++) begin
      send_byte(atr_bytes[i], i == atr_bytes.size() - 1);
    end
    frames++;
  endtask

  // Build an ATR, mostly structurally sound, with random content and a random ending:
  // no check byte, a good one, a bad one, or trailing data.
  function automatic void build_wellformed();
    logic [3:0]  y_bits;
    logic [3:0]  next_y;
    logic [3:0]  k;
    logic [7:0]  b;
    logic [7:0]  xs;
    int unsigned depth;
    int unsigned sec;
    int unsigned ending;
    atr_bytes.delete();
    if ($urandom_range(0, 19) == 0) b = 8'($urandom);
    else b = $urandom_range(0, 1) ? TS_DIRECT : TS_INVERSE;
    atr_bytes.push_back(b);
    y_bits = 4'($urandom);
    k      = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 5));
    depth  = ($urandom_range(0, 14) == 0) ? SECTION_LIMIT + 1 : $urandom_range(1, 3);
    b      = {y_bits, k};
    xs     = b;
    atr_bytes.push_back(b);
    sec = 1;
    // Interface bytes, section by section; a deep chain forces TD onward.
    while (y_bits != 4'd0) begin
      for (int j = 0; j < 3; j++) begin
        if (y_bits[j]) begin
          b  = 8'($urandom);
          xs = xs ^ b;
          atr_bytes.push_back(b);
        end
      end
      if (y_bits[3]) begin
        if (sec >= depth) next_y = 4'd0;
        else if (depth > SECTION_LIMIT) next_y = {1'b1, 3'($urandom)};
        else next_y = 4'($urandom);
        b  = {next_y, 4'($urandom)};
        xs = xs ^ b;
        atr_bytes.push_back(b);
        sec++;
        y_bits = next_y;
      end else begin
        y_bits = 4'd0;
      end
    end
    repeat (k) begin
      b  = 8'($urandom);
      xs = xs ^ b;
      atr_bytes.push_back(b);
    end
    ending = $urandom_range(0, 3);
    if (ending == 1) begin
      atr_bytes.push_back(xs);
    end else if (ending == 2) begin
      atr_bytes.push_back(xs ^ 8'($urandom_range(1, 255)));
    end else if (ending == 3) begin
      atr_bytes.push_back(8'($urandom));
      repeat ($urandom_range(1, 3)) atr_bytes.push_back(8'($urandom));
    end
  endfunction

  // Random bytes; a framed one starts with a valid TS.
  function automatic void build_noise(int unsigned len, logic framed);
    atr_bytes.delete();
    if (framed) atr_bytes.push_back(TS_DIRECT);
    while (atr_bytes.size() < len) atr_bytes.push_back(8'($urandom));
  endfunction

  // Result side: checks each result and stalls on its own pattern, with one
  // long hold-off so that the parser backs up into its input.
  initial begin : receiver
    int unsigned hold_left;
    int unsigned mode;
    int unsigned mode_left;
    int unsigned cyc;
    logic        hold_done;
    logic        take;
    res_t        got;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    cyc       = 0;
    hold_done = 1'b0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (rst_n && result_bus.valid && result_bus.ready) begin
        got.byte_class       = result_bus.byte_class;
        got.section_number   = result_bus.section_number;
        got.historical_index = result_bus.historical_index;
        got.status           = result_bus.status;
        got.done_res         = result_bus.done_res;
        atr_check.check_result(got);
      end
      if (!hold_done && atr_check.checked >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(64, 256);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        take = 1'b0;
        hold_left--;
      end else begin
        case (mode)
          0: take = 1'b1;
          1: take = 1'($urandom_range(0, 1));
          2: take = ($urandom_range(0, 7) != 0);
          default: take = (cyc[2:0] != 3'd5 && cyc[2:0] != 3'd6);
        endcase
      end
      result_bus.ready <= take;
    end
  end

  // Overall time limit.
  initial begin
    #2_000_000;
    $display("smart_card_atr_parser_test: errors");
    $finish;
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int unsigned pick;
    int unsigned drain;
    atr_check  = new();
    burst_left = 3;
    frames     = 0;
    rst_n              <= 1'b0;
    byte_bus.valid     <= 1'b0;
    byte_bus.data_byte <= 8'h00;
    byte_bus.last_byte <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Minimal direct-convention ATR with no check byte.
    atr_bytes = '{8'h3B, 8'h00};
    send_atr();
    // Inverse convention with TA1, one historical byte and a good check byte.
    atr_bytes = '{8'h3F, 8'h11, 8'h96, 8'h41, 8'hC6};
    send_atr();
    // TA1, TB1, TC1 and TD1 present, then a wrong check byte.
    atr_bytes = '{8'h3B, 8'hF0, 8'hAA, 8'hBB, 8'hCC, 8'h00, 8'hFF};
    send_atr();
    // Check candidate followed by trailing data.
    atr_bytes = '{8'h3B, 8'h00, 8'h12, 8'h34};
    send_atr();
    // Bad initial byte, then a lone TS that is too short.
    atr_bytes = '{8'h00, 8'hFF};
    send_atr();
    atr_bytes = '{8'h3B};
    send_atr();
    // Ends while TD1 is still owed.
    atr_bytes = '{8'h3B, 8'h80};
    send_atr();
    // A TD chain that runs past the last section.
    atr_bytes = '{8'h3B, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80};
    send_atr();

    // Random ATRs: mostly well formed, some cut short, some noise, some overlong.
    while (atr_check.parsed + atr_check.ignored < BYTE_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        build_wellformed();
      end else if (pick < 17) begin
        build_wellformed();
        if (atr_bytes.size() > 1) begin
          repeat ($urandom_range(1, atr_bytes.size() - 1)) void'(atr_bytes.pop_back());
        end
      end else if (pick < 19) begin
        build_noise($urandom_range(1, 6), 1'b0);
      end else begin
        build_noise($urandom_range(34, 80), 1'b1);
      end
      send_atr();
    end
    byte_bus.valid <= 1'b0;

    // Let every outstanding result arrive, then allow for the pipeline.
    drain = 0;
    while (atr_check.awaited.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (atr_check.awaited.size() != 0) begin
      $error("%0d results never arrived", atr_check.awaited.size());
      atr_check.errors++;
    end

    $display("Covered %0d ATRs: %0d bytes classified, %0d bytes ignored.",
             frames, atr_check.parsed, atr_check.ignored);
    $display("Byte classes seen %b, final status codes seen %b.",
             atr_check.class_seen[9:0], atr_check.final_seen[8:0]);
    if (atr_check.errors == 0) begin
      $display("smart_card_atr_parser_test: clean");
    end else begin
      $display("smart_card_atr_parser_test: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/scatr_pkg.sv
hw/rtl/scatr_in_if.sv
hw/rtl/scatr_out_if.sv
hw/rtl/scatr_in_stage.sv
hw/rtl/scatr_step.sv
hw/rtl/scatr_out_stage.sv
hw/rtl/smart_card_atr_parser.sv
hw/rtl/scatr_checker.sv
bench/smart_card_atr_parser_test.sv
